>>> src/i2cbb_pkg.sv
`timescale 1ns / 1ps
// i2cbb_pkg: shared constants, command codes and state types for the
// bit-level i2c master sequencer; no dependencies

package i2cbb_pkg;

  localparam int BITS_PER_BYTE = 8;
  localparam int BYTE_W        = 8;
  localparam int OP_W          = 3;
  localparam int STEP_W        = $clog2(3 * BITS_PER_BYTE);

  localparam logic [OP_W-1:0] OP_START    = 3'd0;
  localparam logic [OP_W-1:0] OP_STOP     = 3'd1;
  localparam logic [OP_W-1:0] OP_WRITE    = 3'd2;
  localparam logic [OP_W-1:0] OP_READ     = 3'd3;
  localparam logic [OP_W-1:0] OP_SEND_ACK = 3'd4;
  localparam logic [OP_W-1:0] OP_RECV_ACK = 3'd5;

  localparam logic [STEP_W-1:0] WRITE_LAST = STEP_W'(3 * BITS_PER_BYTE - 1);
  localparam logic [STEP_W-1:0] READ_LAST  = STEP_W'(2 * BITS_PER_BYTE);

  localparam logic [1:0] PH_DATA = 2'd0;
  localparam logic [1:0] PH_HIGH = 2'd1;
  localparam logic [1:0] PH_LOW  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]   cmd;
    logic [STEP_W-1:0] step;
    logic [1:0]        phase;
    logic [BYTE_W-1:0] shift;
    logic              scl;
    logic              sda;
    logic              busy;
    logic [BYTE_W-1:0] rx_byte;
    logic              rx_ack;
  } engine_t;

  typedef struct packed {
    logic              cmd_valid;
    logic [OP_W-1:0]   operation;
    logic [BYTE_W-1:0] tx_byte;
    logic              ack_value;
    logic              sda_in;
  } tick_t;

  typedef struct packed {
    logic              scl;
    logic              sda_out;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] rx_byte;
    logic              rx_ack;
  } result_t;

endpackage

>>> src/i2cbb_if.sv
`timescale 1ns / 1ps
// i2cbb_in_if and i2cbb_out_if: valid/ready channels for tick requests
// and results; depends on i2cbb_pkg

interface i2cbb_in_if;
  import i2cbb_pkg::*;

  logic              valid;
  logic              ready;
  logic              cmd_valid;
  logic [OP_W-1:0]   operation;
  logic [BYTE_W-1:0] tx_byte;
  logic              ack_value;
  logic              sda_in;

  modport source (
    output valid, cmd_valid, operation, tx_byte, ack_value, sda_in,
    input  ready
  );
  modport sink (
    input  valid, cmd_valid, operation, tx_byte, ack_value, sda_in,
    output ready
  );
endinterface

interface i2cbb_out_if;
  import i2cbb_pkg::*;

  logic              valid;
  logic              ready;
  logic              scl;
  logic              sda_out;
  logic              busy_res;
  logic              done_res;
  logic [BYTE_W-1:0] rx_byte;
  logic              rx_ack;

  modport source (
    output valid, scl, sda_out, busy_res, done_res, rx_byte, rx_ack,
    input  ready
  );
  modport sink (
    input  valid, scl, sda_out, busy_res, done_res, rx_byte, rx_ack,
    output ready
  );
endinterface

>>> src/i2c_bitbang_master_sequencer.sv
`timescale 1ns / 1ps
// i2c_bitbang_master_sequencer: top level, one result per tick request
// path: an accepted request goes to the request register, then through the step logic into the result register on res
// throughput: one request per cycle, set by the single step path between
// the request register and the result register; a stalled res stalls req
// reset: scl and sda released high, engine idle, received byte and ack zero
// depends on i2cbb_pkg, i2cbb_if and i2cbb_sequencer

module i2c_bitbang_master_sequencer (
  input logic         clk,
  input logic         rst,
  i2cbb_in_if.sink    req,
  i2cbb_out_if.source res
);
  import i2cbb_pkg::*;

  tick_t   req_tick;
  result_t res_data;

  assign req_tick.cmd_valid = req.cmd_valid;
  assign req_tick.operation = req.operation;
  assign req_tick.tx_byte   = req.tx_byte;
  assign req_tick.ack_value = req.ack_value;
  assign req_tick.sda_in    = req.sda_in;

  i2cbb_sequencer u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_tick  (req_tick),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_data  (res_data)
  );

  assign res.scl      = res_data.scl;
  assign res.sda_out  = res_data.sda_out;
  assign res.busy_res = res_data.busy_res;
  assign res.done_res = res_data.done_res;
  assign res.rx_byte  = res_data.rx_byte;
  assign res.rx_ack   = res_data.rx_ack;

endmodule

>>> src/i2cbb_step.sv
`timescale 1ns / 1ps
// i2cbb_step: one pin step of the bus sequence, from engine state and one
// tick to the next engine state and the tick's result; depends on i2cbb_pkg

module i2cbb_step (
  input  i2cbb_pkg::engine_t cur,
  input  i2cbb_pkg::tick_t   tick,
  output i2cbb_pkg::engine_t nxt,
  output i2cbb_pkg::result_t res
);
  import i2cbb_pkg::*;

  engine_t st;
  logic    last;
  logic    done;

  always_comb begin
    st   = cur;
    last = 1'b0;
    done = 1'b0;

    if (!cur.busy && tick.cmd_valid && tick.operation <= OP_RECV_ACK) begin
      st.cmd   = tick.operation;
      st.step  = '0;
      st.phase = PH_DATA;
      st.busy  = 1'b1;
      if (tick.operation == OP_WRITE) begin
        st.shift = tick.tx_byte;
      end
    end

    if (st.busy) begin
      case (st.cmd)
        OP_START: begin
          case (st.step)
            STEP_W'(0): st.sda = 1'b1;
            STEP_W'(1): st.scl = 1'b1;
            STEP_W'(2): st.sda = 1'b0;
            default:    st.scl = 1'b0;
          endcase
          last = (st.step >= STEP_W'(3));
        end
        OP_STOP: begin
          case (st.step)
            STEP_W'(0): st.sda = 1'b0;
            STEP_W'(1): st.scl = 1'b1;
            default:    st.sda = 1'b1;
          endcase
          last = (st.step >= STEP_W'(2));
        end
        OP_WRITE: begin
          case (st.phase)
            PH_DATA: st.sda = st.shift[BYTE_W-1];
            PH_HIGH: st.scl = 1'b1;
            default: begin
              st.scl   = 1'b0;
              st.shift = {st.shift[BYTE_W-2:0], 1'b0};
            end
          endcase
          last = (st.step >= WRITE_LAST);
        end
        OP_READ: begin
          if (st.step == '0) begin
            st.sda   = 1'b1;
            st.shift = '0;
          end else if (st.step[0]) begin
            st.scl = 1'b1;
          end else begin
            st.shift = {st.shift[BYTE_W-2:0], tick.sda_in};
            st.scl   = 1'b0;
          end
          last = (st.step >= READ_LAST);
          if (last) begin
            st.rx_byte = st.shift;
          end
        end
        OP_SEND_ACK: begin
          case (st.step)
            STEP_W'(0): st.sda = tick.ack_value;
            STEP_W'(1): st.scl = 1'b1;
            default:    st.scl = 1'b0;
          endcase
          last = (st.step >= STEP_W'(2));
        end
        OP_RECV_ACK: begin
          case (st.step)
            STEP_W'(0): st.sda = 1'b1;
            STEP_W'(1): st.scl = 1'b1;
            default: begin
              st.rx_ack = tick.sda_in;
              st.scl    = 1'b0;
            end
          endcase
          last = (st.step >= STEP_W'(2));
        end
        default: last = 1'b1;
      endcase

      if (last) begin
        st.busy  = 1'b0;
        st.step  = '0;
        st.phase = PH_DATA;
        done     = 1'b1;
      end else begin
        st.step  = st.step + STEP_W'(1);
        st.phase = (st.phase == PH_LOW) ? PH_DATA : st.phase + 2'd1;
      end
    end
  end

  assign nxt          = st;
  assign res.scl      = st.scl;
  assign res.sda_out  = st.sda;
  assign res.busy_res = st.busy;
  assign res.done_res = done;
  assign res.rx_byte  = st.rx_byte;
  assign res.rx_ack   = st.rx_ack;

endmodule

>>> src/i2cbb_sequencer.sv
`timescale 1ns / 1ps
// i2cbb_sequencer: request register, engine state and result register
// around the step logic; depends on i2cbb_pkg and i2cbb_step

module i2cbb_sequencer (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  i2cbb_pkg::tick_t    req_tick,
  output logic                res_valid,
  input  logic                res_ready,
  output i2cbb_pkg::result_t  res_data
);
  import i2cbb_pkg::*;

  logic    tick_v;
  tick_t   tick;
  engine_t eng;
  engine_t eng_next;
  result_t result_next;
  logic    advance;

  i2cbb_step u_step (
    .cur  (eng),
    .tick (tick),
    .nxt  (eng_next),
    .res  (result_next)
  );

  assign advance   = tick_v && (!res_valid || res_ready);
  assign req_ready = !tick_v || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_v <= 1'b0;
    end else if (req_ready) begin
      tick_v <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      tick <= req_tick;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eng.cmd     <= OP_START;
      eng.step    <= '0;
      eng.phase   <= PH_DATA;
      eng.shift   <= '0;
      eng.scl     <= 1'b1;
      eng.sda     <= 1'b1;
      eng.busy    <= 1'b0;
      eng.rx_byte <= '0;
      eng.rx_ack  <= 1'b0;
    end else if (advance) begin
      eng <= eng_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_data <= result_next;
    end
  end

endmodule
